// ===== hdl/las_pkg.sv =====
// ----------------------------------------------------------------------------
// las_pkg
// Shared types and constants of the lock actuator sequencer: item layouts,
// configuration set, register indexes, command, status and outcome codes,
// and the wrapped angle difference helpers.
// ----------------------------------------------------------------------------
package las_pkg;

  localparam int ANG_W      = 12;
  localparam int ANG_FULL   = 1 << ANG_W;
  localparam int ANG_HALF   = ANG_FULL >> 1;
  localparam int SG_W       = 16;
  localparam int STEP_W     = 17;
  localparam int TRV_W      = 18;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [SG_W-1:0]         SG_INVALID    = 16'hFFFF;
  localparam logic [STEP_W-1:0]       LOCK_STALL_MIN   = 17'd200;
  localparam logic [STEP_W-1:0]       UNLOCK_STALL_MIN = 17'd500;
  localparam logic signed [TRV_W-1:0] TRAVEL_MAX    = 18'sd131071;

  localparam logic [1:0] OP_TICK   = 2'd0;
  localparam logic [1:0] OP_LOCK   = 2'd1;
  localparam logic [1:0] OP_UNLOCK = 2'd2;

  localparam logic [2:0] ST_UNCAL    = 3'd0;
  localparam logic [2:0] ST_LOCKED   = 3'd1;
  localparam logic [2:0] ST_UNLOCKED = 3'd2;
  localparam logic [2:0] ST_MID      = 3'd3;
  localparam logic [2:0] ST_MOVING   = 3'd4;

  localparam logic [2:0] OC_NONE       = 3'd0;
  localparam logic [2:0] OC_OK         = 3'd1;
  localparam logic [2:0] OC_RETURNED   = 3'd2;
  localparam logic [2:0] OC_NOT_CAL    = 3'd3;
  localparam logic [2:0] OC_INCOMPLETE = 3'd4;

  localparam logic [CFG_IDX_W-1:0] CFG_CALIBRATED = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LOCK_POS   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_UNLOCK_POS = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_TOLERANCE  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_STALL_LIM  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_STEP_LIM   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_UNLOCK_TRV = 3'd6;

  localparam logic [ANG_W-1:0] TOL_RESET      = 12'd57;
  localparam logic [15:0]      STEP_LIM_RESET = 16'd4096;
  localparam logic [15:0]      TRAVEL_RESET   = 16'd3982;

  typedef struct packed {
    logic [1:0]       operation;
    logic [ANG_W-1:0] angle;
    logic [SG_W-1:0]  stall_reading;
  } in_item_t;

  typedef struct packed {
    logic       step_pulse;
    logic       direction;
    logic       motor_enable;
    logic [2:0] lock_status;
    logic [2:0] outcome;
    logic       key_event;
  } out_item_t;

  typedef struct packed {
    logic             calibrated_flag;
    logic [ANG_W-1:0] lock_position;
    logic [ANG_W-1:0] unlock_position;
    logic [ANG_W-1:0] angle_tolerance;
    logic [14:0]      stall_limit;
    logic [15:0]      step_limit;
    logic [15:0]      unlock_travel;
  } las_cfg_t;

  function automatic logic signed [ANG_W:0] ang_sdiff(input logic [ANG_W-1:0] from_a,
                                                     input logic [ANG_W-1:0] to_a);
    logic [ANG_W-1:0] d;
    d = to_a - from_a;
    if ({1'b0, d} > (ANG_W+1)'(ANG_HALF)) begin
      return $signed({1'b0, d}) - $signed((ANG_W+1)'(ANG_FULL));
    end
    return $signed({1'b0, d});
  endfunction

  function automatic logic [ANG_W-1:0] ang_mdiff(input logic [ANG_W-1:0] from_a,
                                                input logic [ANG_W-1:0] to_a);
    logic [ANG_W-1:0] d;
    d = to_a - from_a;
    if ({1'b0, d} > (ANG_W+1)'(ANG_HALF)) begin
      return -d;
    end
    return d;
  endfunction

endpackage

// ===== hdl/las_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// las_cfg_regs
// Configuration register file: one write per handshake, index selects the
// register, writes past the last register are dropped.
// ----------------------------------------------------------------------------
module las_cfg_regs import las_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  wr_en,
  input  logic [CFG_IDX_W-1:0]  wr_index,
  input  logic [CFG_DATA_W-1:0] wr_data,
  output las_cfg_t              cfg
);

  las_cfg_t cfg_r, cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (wr_index)
        CFG_CALIBRATED: cfg_nxt.calibrated_flag = wr_data[0];
        CFG_LOCK_POS:   cfg_nxt.lock_position   = wr_data[ANG_W-1:0];
        CFG_UNLOCK_POS: cfg_nxt.unlock_position = wr_data[ANG_W-1:0];
        CFG_TOLERANCE:  cfg_nxt.angle_tolerance = wr_data[ANG_W-1:0];
        CFG_STALL_LIM:  cfg_nxt.stall_limit     = wr_data[14:0];
        CFG_STEP_LIM:   cfg_nxt.step_limit      = wr_data[15:0];
        CFG_UNLOCK_TRV: cfg_nxt.unlock_travel   = wr_data[15:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.calibrated_flag <= 1'b0;
      cfg_r.lock_position   <= '0;
      cfg_r.unlock_position <= '0;
      cfg_r.angle_tolerance <= TOL_RESET;
      cfg_r.stall_limit     <= '0;
      cfg_r.step_limit      <= STEP_LIM_RESET;
      cfg_r.unlock_travel   <= TRAVEL_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

// ===== hdl/las_core.sv =====
// ----------------------------------------------------------------------------
// las_core
// Sequencer state and its one-tick update: idle key detection and position
// classification, lock move with return on failure, unlock move with travel
// accumulation. State advances only when an item is taken.
// ----------------------------------------------------------------------------
module las_core import las_pkg::*; #(
  parameter int CHECK_INTERVAL = 50
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      fire,
  input  in_item_t  item,
  input  las_cfg_t  cfg,
  output out_item_t res
);

  localparam int CHK_W = (CHECK_INTERVAL > 1) ? $clog2(CHECK_INTERVAL) : 1;
  localparam int KEY_W = ANG_W + 9;
  localparam int SC_W  = 25;

  typedef enum logic [3:0] {
    PH_IDLE   = 4'b0001,
    PH_LOCK   = 4'b0010,
    PH_RETURN = 4'b0100,
    PH_UNLOCK = 4'b1000
  } phase_t;

  phase_t                    phase_r, phase_nxt;
  logic [STEP_W-1:0]         step_r, step_nxt;
  logic [CHK_W-1:0]          chk_r, chk_nxt;
  logic [ANG_W-1:0]          start_r, start_nxt;
  logic [ANG_W-1:0]          last_r, last_nxt;
  logic signed [TRV_W-1:0]   travel_r, travel_nxt;
  logic [2:0]                status_r, status_nxt;

  logic [ANG_W-1:0]          ang;
  logic [ANG_W-1:0]          key_mag, lock_mag, unlock_mag, start_mag;
  logic [KEY_W-1:0]          key_prod;
  logic                      key_hit;
  logic [2:0]                class_st;
  logic [15:0]               lim;
  logic [STEP_W-1:0]         cnt_inc;
  logic [CHK_W-1:0]          chk_inc;
  logic                      check;
  logic                      stall;
  logic signed [ANG_W:0]     sd;
  logic signed [TRV_W:0]     t_sum;
  logic signed [TRV_W-1:0]   t_new;
  logic [TRV_W-2:0]          t_abs;
  logic [SC_W-1:0]           t_scaled, target;
  logic                      near_lock, reach, unlock_ok;

  assign ang        = item.angle;
  assign key_mag    = ang_mdiff(last_r, ang);
  assign lock_mag   = ang_mdiff(ang, cfg.lock_position);
  assign unlock_mag = ang_mdiff(ang, cfg.unlock_position);
  assign start_mag  = ang_mdiff(ang, start_r);
  assign key_prod   = KEY_W'(key_mag) * KEY_W'(360);
  assign key_hit    = cfg.calibrated_flag && (key_prod > KEY_W'(5 * ANG_FULL));
  assign near_lock  = lock_mag < cfg.angle_tolerance;

  always_comb begin
    priority if (!cfg.calibrated_flag) begin
      class_st = ST_UNCAL;
    end else if (lock_mag <= cfg.angle_tolerance) begin
      class_st = ST_LOCKED;
    end else if (unlock_mag <= cfg.angle_tolerance) begin
      class_st = ST_UNLOCKED;
    end else begin
      class_st = ST_MID;
    end
  end

  assign lim     = (cfg.step_limit == '0) ? 16'd1 : cfg.step_limit;
  assign cnt_inc = (step_r == '1) ? step_r : step_r + STEP_W'(1);
  assign chk_inc = (chk_r == CHK_W'(CHECK_INTERVAL - 1)) ? '0 : chk_r + CHK_W'(1);
  assign check   = (chk_inc == '0);
  assign stall   = ({1'b0, item.stall_reading} < {cfg.stall_limit, 2'b00} >> 1)
                   && (item.stall_reading != SG_INVALID);

  assign sd    = ang_sdiff(last_r, ang);
  assign t_sum = (TRV_W+1)'(travel_r) + (TRV_W+1)'(sd);

  always_comb begin
    priority if (t_sum > (TRV_W+1)'(TRAVEL_MAX)) begin
      t_new = TRAVEL_MAX;
    end else if (t_sum < -(TRV_W+1)'(TRAVEL_MAX)) begin
      t_new = -TRAVEL_MAX;
    end else begin
      t_new = t_sum[TRV_W-1:0];
    end
  end

  assign t_abs     = t_new[TRV_W-1] ? (TRV_W-1)'(-t_new) : (TRV_W-1)'(t_new);
  assign t_scaled  = SC_W'(t_abs) * SC_W'(100);
  assign target    = SC_W'(cfg.unlock_travel) * SC_W'(100);
  assign reach     = (t_scaled + SC_W'(3 * ANG_FULL)) >= target;
  assign unlock_ok = (t_scaled + SC_W'(5 * ANG_FULL)) >= target;

  always_comb begin
    phase_nxt  = phase_r;
    step_nxt   = step_r;
    chk_nxt    = chk_r;
    start_nxt  = start_r;
    last_nxt   = ang;
    travel_nxt = travel_r;
    status_nxt = status_r;
    res        = '0;
    if (phase_r == PH_IDLE) begin
      res.key_event = key_hit;
      status_nxt    = class_st;
      if (item.operation == OP_LOCK || item.operation == OP_UNLOCK) begin
        priority if (!cfg.calibrated_flag) begin
          res.outcome = OC_NOT_CAL;
        end else if (item.operation == OP_LOCK) begin
          if (near_lock) begin
            status_nxt  = ST_LOCKED;
            res.outcome = OC_OK;
          end else begin
            phase_nxt        = PH_LOCK;
            step_nxt         = '0;
            chk_nxt          = '0;
            start_nxt        = ang;
            status_nxt       = ST_MOVING;
            res.motor_enable = 1'b1;
          end
        end else begin
          phase_nxt        = PH_UNLOCK;
          step_nxt         = '0;
          chk_nxt          = '0;
          travel_nxt       = '0;
          status_nxt       = ST_MOVING;
          res.motor_enable = 1'b1;
          res.direction    = 1'b1;
        end
      end
    end else begin
      res.step_pulse   = 1'b1;
      res.motor_enable = 1'b1;
      step_nxt         = cnt_inc;
      chk_nxt          = chk_inc;
      unique case (phase_r)
        PH_LOCK: begin
          priority if (check && near_lock) begin
            phase_nxt   = PH_IDLE;
            status_nxt  = ST_LOCKED;
            res.outcome = OC_OK;
          end else if ((check && stall && cnt_inc > LOCK_STALL_MIN) ||
                       (cnt_inc >= {1'b0, lim} && !near_lock)) begin
            phase_nxt = PH_RETURN;
            step_nxt  = '0;
            chk_nxt   = '0;
          end else if (cnt_inc >= {1'b0, lim}) begin
            phase_nxt   = PH_IDLE;
            status_nxt  = ST_LOCKED;
            res.outcome = OC_OK;
          end else begin
          end
        end
        PH_RETURN: begin
          res.direction = 1'b1;
          if ((check && start_mag < cfg.angle_tolerance) || cnt_inc >= {1'b0, lim}) begin
            phase_nxt   = PH_IDLE;
            status_nxt  = ST_UNLOCKED;
            res.outcome = OC_RETURNED;
          end
        end
        PH_UNLOCK: begin
          res.direction = 1'b1;
          travel_nxt    = t_new;
          if ((check && reach) || (check && stall && cnt_inc > UNLOCK_STALL_MIN) ||
              cnt_inc >= {lim, 1'b0}) begin
            phase_nxt = PH_IDLE;
            if (unlock_ok) begin
              status_nxt  = ST_UNLOCKED;
              res.outcome = OC_OK;
            end else begin
              status_nxt  = ST_MID;
              res.outcome = OC_INCOMPLETE;
            end
          end
        end
        default: ;
      endcase
    end
    res.lock_status = status_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_IDLE;
      step_r   <= '0;
      chk_r    <= '0;
      start_r  <= '0;
      last_r   <= '0;
      travel_r <= '0;
      status_r <= ST_UNCAL;
    end else if (fire) begin
      phase_r  <= phase_nxt;
      step_r   <= step_nxt;
      chk_r    <= chk_nxt;
      start_r  <= start_nxt;
      last_r   <= last_nxt;
      travel_r <= travel_nxt;
      status_r <= status_nxt;
    end
  end

endmodule

// ===== hdl/lock_actuator_sequencer.sv =====
// ----------------------------------------------------------------------------
// lock_actuator_sequencer
// Takes one tick item per clock (angle, stall reading, command) while the
// result port is not stalled, and returns one result item per tick with step,
// direction, enable, status and outcome. An item is registered on entry, the
// sequencer state advances and the result lands in an output register, so an
// item's result appears on the result port once the sequencer has fired on it
// from the input register, and a new item is taken every cycle unless the
// result is stalled. A stalled result holds the pipeline only once both
// registers are full. The configuration port always accepts a write and
// takes effect on the next item; write it only while no item is in flight.
// ----------------------------------------------------------------------------
module lock_actuator_sequencer import las_pkg::*; #(
  parameter int CHECK_INTERVAL = 50
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  in_item_t              in_item,
  output logic                  out_valid,
  input  logic                  out_stall,
  output out_item_t             out_item,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  las_cfg_t  cfg;
  in_item_t  in_r;
  logic      in_valid_r;
  out_item_t out_r;
  logic      out_valid_r;
  out_item_t res;
  logic      fire;
  logic      in_take;

  assign cfg_ready = 1'b1;
  assign fire      = in_valid_r && (!out_valid_r || !out_stall);
  assign in_stall  = in_valid_r && !fire;
  assign in_take   = in_valid && !in_stall;

  las_cfg_regs u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  las_core #(.CHECK_INTERVAL(CHECK_INTERVAL)) u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .fire  (fire),
    .item  (in_r),
    .cfg   (cfg),
    .res   (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_take) begin
        in_valid_r <= 1'b1;
      end else if (fire) begin
        in_valid_r <= 1'b0;
      end
      if (fire) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_r <= in_item;
    end
    if (fire) begin
      out_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_r;

endmodule

// ===== hdl/las_checker.sv =====
// ----------------------------------------------------------------------------
// las_checker
// Port-level checks of the lock actuator sequencer: result hold under stall
// and consistency of the motion fields of each result item.
// ----------------------------------------------------------------------------
module las_checker import las_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  input logic      out_valid,
  input logic      out_stall,
  input out_item_t out_item
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_item))
    else $error("stalled result item changed");

  a_key_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_item.key_event && out_item.step_pulse))
    else $error("key event during a move");

  a_pulse_en: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_item.step_pulse || out_item.lock_status == ST_MOVING)
      |-> out_item.motor_enable)
    else $error("step or moving status without motor enable");

  a_outcome_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.outcome != OC_NONE |-> out_item.lock_status != ST_MOVING)
    else $error("outcome reported while still moving");

endmodule

bind lock_actuator_sequencer las_checker u_las_checker (.*);

// ===== dv/lock_actuator_sequencer_tb.sv =====
// ----------------------------------------------------------------------------
// lock_actuator_sequencer_tb
// Drives encoder ticks, lock and unlock commands into the sequencer and
// checks every actuation item against a cycle-free model of the idle
// classification and the lock, return and unlock moves. A short table of
// hand-picked ticks comes first, then randomized phases under a range of
// calibration, tolerance, stall and step-limit settings, with random gaps on
// the input and random back-pressure on the output.
// ----------------------------------------------------------------------------
module lock_actuator_sequencer_tb;
  import las_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CHK = 50;
  localparam logic [1:0] OP_SPARE = 2'd3;

  typedef enum logic [1:0] {MV_IDLE, MV_LOCK, MV_RETURN, MV_UNLOCK} move_e;
  typedef enum int {AIM, SWEEP, SPIN, JITTER} drift_e;

  typedef struct packed {
    bit        recfg;
    in_item_t  it;
    bit        pin;
    out_item_t want;
  } step_row_t;

  logic                  clk;
  logic                  rst_n     = 1'b0;
  logic                  in_valid  = 1'b0;
  logic                  in_stall;
  in_item_t              in_item   = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  out_item_t             out_item;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  las_cfg_t         cfg_now;
  move_e            mv_phase   = MV_IDLE;
  move_e            phase_seen = MV_IDLE;
  int               mv_steps   = 0;
  int               travel     = 0;
  logic [ANG_W-1:0] mv_origin  = '0;
  logic [ANG_W-1:0] seen_ang   = '0;
  logic [2:0]       pos_status = ST_UNCAL;

  out_item_t actuation_q[$];
  step_row_t dir_rows[$];
  int        bad_actuations = 0;
  int        hold_left      = 0;
  bit        calm_in        = 1'b0;
  bit        calm_out       = 1'b0;
  bit        pin_en         = 1'b0;
  out_item_t pin_val        = '0;
  drift_e    drift_mode     = AIM;

  lock_actuator_sequencer #(.CHECK_INTERVAL(CHK)) u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("Verification failed");
    $finish;
  end

  function automatic int turn_delta(logic [ANG_W-1:0] from_a, logic [ANG_W-1:0] to_a);
    int d;
    d = (int'(to_a) - int'(from_a)) & (ANG_FULL - 1);
    return (d > ANG_HALF) ? d - ANG_FULL : d;
  endfunction

  function automatic int turn_gap(logic [ANG_W-1:0] from_a, logic [ANG_W-1:0] to_a);
    int s;
    s = turn_delta(from_a, to_a);
    return (s < 0) ? -s : s;
  endfunction

  function automatic logic [2:0] where_is(logic [ANG_W-1:0] a);
    if (!cfg_now.calibrated_flag) return ST_UNCAL;
    if (turn_gap(a, cfg_now.lock_position) <= int'(cfg_now.angle_tolerance)) return ST_LOCKED;
    if (turn_gap(a, cfg_now.unlock_position) <= int'(cfg_now.angle_tolerance)) begin
      return ST_UNLOCKED;
    end
    return ST_MID;
  endfunction

  function automatic bit stalled(logic [SG_W-1:0] sg);
    return int'(sg) < 2 * int'(cfg_now.stall_limit) && sg != SG_INVALID;
  endfunction

  function automatic out_item_t sequence_tick(in_item_t it);
    out_item_t        r;
    int               lim, tol, trgt, t, mag;
    logic [ANG_W-1:0] prev;
    bit               chk, near, ok_end, fail_end, done;
    r = '0;
    tol = int'(cfg_now.angle_tolerance);
    lim = (cfg_now.step_limit == 0) ? 1 : int'(cfg_now.step_limit);
    trgt = int'(cfg_now.unlock_travel) * 100;
    if (mv_phase == MV_IDLE) begin
      if (cfg_now.calibrated_flag && turn_gap(seen_ang, it.angle) * 360 > 5 * ANG_FULL) begin
        r.key_event = 1'b1;
      end
      seen_ang = it.angle;
      pos_status = where_is(it.angle);
      if (it.operation == OP_LOCK || it.operation == OP_UNLOCK) begin
        if (!cfg_now.calibrated_flag) begin
          r.outcome = OC_NOT_CAL;
        end else if (it.operation == OP_LOCK) begin
          if (turn_gap(it.angle, cfg_now.lock_position) < tol) begin
            pos_status = ST_LOCKED;
            r.outcome = OC_OK;
          end else begin
            mv_phase = MV_LOCK;
            mv_steps = 0;
            mv_origin = it.angle;
            pos_status = ST_MOVING;
            r.motor_enable = 1'b1;
          end
        end else begin
          mv_phase = MV_UNLOCK;
          mv_steps = 0;
          travel = 0;
          pos_status = ST_MOVING;
          r.motor_enable = 1'b1;
          r.direction = 1'b1;
        end
      end
    end else begin
      prev = seen_ang;
      seen_ang = it.angle;
      r.step_pulse = 1'b1;
      r.motor_enable = 1'b1;
      if (mv_steps < 'h1FFFF) mv_steps++;
      chk = (mv_steps % CHK) == 0;
      case (mv_phase)
        MV_LOCK: begin
          near = turn_gap(it.angle, cfg_now.lock_position) < tol;
          ok_end = chk && near;
          fail_end = 1'b0;
          if (!ok_end && chk && stalled(it.stall_reading) &&
              mv_steps > int'(LOCK_STALL_MIN)) begin
            fail_end = 1'b1;
          end else if (!ok_end && mv_steps >= lim) begin
            ok_end = near;
            fail_end = !near;
          end
          if (ok_end) begin
            mv_phase = MV_IDLE;
            pos_status = ST_LOCKED;
            r.outcome = OC_OK;
          end else if (fail_end) begin
            mv_phase = MV_RETURN;
            mv_steps = 0;
          end
        end
        MV_RETURN: begin
          r.direction = 1'b1;
          if ((chk && turn_gap(it.angle, mv_origin) < tol) || mv_steps >= lim) begin
            mv_phase = MV_IDLE;
            pos_status = ST_UNLOCKED;
            r.outcome = OC_RETURNED;
          end
        end
        default: begin
          r.direction = 1'b1;
          t = travel + turn_delta(prev, it.angle);
          if (t > int'(TRAVEL_MAX)) t = int'(TRAVEL_MAX);
          if (t < -int'(TRAVEL_MAX)) t = -int'(TRAVEL_MAX);
          travel = t;
          mag = ((t < 0) ? -t : t) * 100;
          done = (chk && mag + 3 * ANG_FULL >= trgt) ||
                 (chk && stalled(it.stall_reading) && mv_steps > int'(UNLOCK_STALL_MIN)) ||
                 mv_steps >= 2 * lim;
          if (done) begin
            mv_phase = MV_IDLE;
            if (mag + 5 * ANG_FULL >= trgt) begin
              pos_status = ST_UNLOCKED;
              r.outcome = OC_OK;
            end else begin
              pos_status = ST_MID;
              r.outcome = OC_INCOMPLETE;
            end
          end
        end
      endcase
    end
    r.lock_status = pos_status;
    return r;
  endfunction

  task automatic flag_miss(string what, out_item_t want, out_item_t got);
    if (bad_actuations < 10) begin
      $display("%s at %0t: want p%0d d%0d e%0d st%0d oc%0d k%0d got p%0d d%0d e%0d st%0d oc%0d k%0d",
               what, $time, want.step_pulse, want.direction, want.motor_enable,
               want.lock_status, want.outcome, want.key_event, got.step_pulse,
               got.direction, got.motor_enable, got.lock_status, got.outcome, got.key_event);
    end
    bad_actuations++;
  endtask

  always @(posedge clk) begin : watch
    out_item_t calc, want;
    if (rst_n && in_valid && !in_stall) begin
      calc = sequence_tick(in_item);
      actuation_q.push_back(pin_en ? pin_val : calc);
    end
    if (rst_n && out_valid && !out_stall) begin
      if (actuation_q.size() == 0) begin
        flag_miss("unexpected item", '0, out_item);
      end else begin
        want = actuation_q.pop_front();
        if (out_item.step_pulse !== want.step_pulse || out_item.direction !== want.direction ||
            out_item.motor_enable !== want.motor_enable ||
            out_item.lock_status !== want.lock_status || out_item.outcome !== want.outcome ||
            out_item.key_event !== want.key_event) begin
          flag_miss("mismatch", want, out_item);
        end
      end
      hold_left = calm_out ? 0 : $urandom_range(0, 6);
    end
  end

  always @(negedge clk) begin
    out_stall <= (hold_left != 0);
    if (hold_left != 0) hold_left = hold_left - 1;
  end

  function automatic las_cfg_t make_settings(bit cal, int lp, int up, int tol, int sl,
                                             int stl, int ut);
    las_cfg_t c;
    c.calibrated_flag = cal;
    c.lock_position   = lp[ANG_W-1:0];
    c.unlock_position = up[ANG_W-1:0];
    c.angle_tolerance = tol[ANG_W-1:0];
    c.stall_limit     = sl[14:0];
    c.step_limit      = stl[15:0];
    c.unlock_travel   = ut[15:0];
    return c;
  endfunction

  function automatic las_cfg_t random_settings();
    int tol, sl, stl, ut;
    tol = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 2048) : $urandom_range(0, 300);
    case ($urandom_range(0, 2))
      0: sl = 0;
      1: sl = $urandom_range(0, 32767);
      default: sl = 32767;
    endcase
    stl = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 3) : $urandom_range(20, 150);
    ut = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535) : $urandom_range(0, 2500);
    return make_settings($urandom_range(0, 7) != 0, $urandom_range(0, 4095),
                         $urandom_range(0, 4095), tol, sl, stl, ut);
  endfunction

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      CFG_CALIBRATED: cfg_now.calibrated_flag = val[0];
      CFG_LOCK_POS:   cfg_now.lock_position   = val[ANG_W-1:0];
      CFG_UNLOCK_POS: cfg_now.unlock_position = val[ANG_W-1:0];
      CFG_TOLERANCE:  cfg_now.angle_tolerance = val[ANG_W-1:0];
      CFG_STALL_LIM:  cfg_now.stall_limit     = val[14:0];
      CFG_STEP_LIM:   cfg_now.step_limit      = val;
      CFG_UNLOCK_TRV: cfg_now.unlock_travel   = val;
      default: ;
    endcase
    @(negedge clk);
  endtask

  task automatic write_settings(las_cfg_t c);
    write_reg(CFG_CALIBRATED, CFG_DATA_W'(c.calibrated_flag));
    write_reg(CFG_LOCK_POS,   CFG_DATA_W'(c.lock_position));
    write_reg(CFG_UNLOCK_POS, CFG_DATA_W'(c.unlock_position));
    write_reg(CFG_TOLERANCE,  CFG_DATA_W'(c.angle_tolerance));
    write_reg(CFG_STALL_LIM,  CFG_DATA_W'(c.stall_limit));
    write_reg(CFG_STEP_LIM,   c.step_limit);
    write_reg(CFG_UNLOCK_TRV, c.unlock_travel);
    cfg_valid <= 1'b0;
  endtask

  // drop valid, drain, then hold past the pipeline before touching registers
  task automatic settle();
    in_valid <= 1'b0;
    while (actuation_q.size() != 0) @(negedge clk);
    repeat (3) @(negedge clk);
  endtask

  task automatic send(in_item_t it);
    int gap;
    gap = calm_in ? 0 : $urandom_range(0, 6);
    if ($urandom_range(0, 29) == 0) calm_in = !calm_in;
    if ($urandom_range(0, 29) == 0) calm_out = !calm_out;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  function automatic logic [SG_W-1:0] pick_reading();
    int lim2;
    lim2 = 2 * int'(cfg_now.stall_limit);
    case ($urandom_range(0, 7))
      0: return SG_INVALID;
      1: return '0;
      2, 3, 4: if (lim2 > 0) return SG_W'($urandom_range(0, lim2 - 1));
      default: return SG_W'($urandom_range(0, 65535));
    endcase
    return SG_W'($urandom);
  endfunction

  function automatic logic [ANG_W-1:0] near_of(logic [ANG_W-1:0] pos);
    int spread;
    spread = int'(cfg_now.angle_tolerance) + 3;
    if (spread > 300) spread = 300;
    return ANG_W'(int'(pos) + int'($urandom_range(0, 2 * spread)) - spread);
  endfunction

  function automatic drift_e draw_mode();
    if (mv_phase == MV_UNLOCK) begin
      case ($urandom_range(0, 2))
        0: return SWEEP;
        1: return SPIN;
        default: return JITTER;
      endcase
    end
    return ($urandom_range(0, 9) < 6) ? AIM : JITTER;
  endfunction

  function automatic logic [ANG_W-1:0] next_angle(logic [ANG_W-1:0] goal);
    int sd, stp;
    case (drift_mode)
      AIM: begin
        sd = turn_delta(seen_ang, goal);
        stp = $urandom_range(0, 40);
        if (sd > stp) sd = stp;
        if (sd < -stp) sd = -stp;
      end
      SWEEP: sd = $urandom_range(0, 80);
      SPIN: sd = $urandom_range(1500, 2048);
      default: sd = int'($urandom_range(0, 40)) - 20;
    endcase
    return ANG_W'(int'(seen_ang) + sd);
  endfunction

  task automatic run_phase(las_cfg_t c, int budget, int unlock_pct);
    int               sent, pick;
    logic [1:0]       op;
    logic [ANG_W-1:0] ang;
    settle();
    write_settings(c);
    for (sent = 0; sent < budget; sent++) begin
      if (mv_phase != phase_seen) begin
        phase_seen = mv_phase;
        drift_mode = draw_mode();
      end
      if (mv_phase == MV_IDLE) begin
        pick = $urandom_range(0, 99);
        case ($urandom_range(0, 3))
          0: ang = near_of(cfg_now.lock_position);
          1: ang = near_of(cfg_now.unlock_position);
          2: ang = ANG_W'($urandom);
          default: ang = ANG_W'(int'(seen_ang) + int'($urandom_range(0, 112)) - 56);
        endcase
        if (pick < 15) begin
          op = 2'($urandom_range(0, 3));
        end else if (pick < 45) begin
          op = ($urandom_range(0, 4) == 0) ? OP_SPARE : OP_TICK;
        end else begin
          op = ($urandom_range(0, 99) < unlock_pct) ? OP_UNLOCK : OP_LOCK;
        end
      end else begin
        op = 2'($urandom_range(0, 3));
        ang = next_angle((mv_phase == MV_RETURN) ? mv_origin : cfg_now.lock_position);
      end
      send({op, ang, pick_reading()});
    end
  endtask

  function automatic void add_row(bit recfg, logic [1:0] op, logic [ANG_W-1:0] ang,
                                  logic [SG_W-1:0] sg, bit pin, out_item_t want);
    step_row_t r;
    r.recfg = recfg;
    r.it    = {op, ang, sg};
    r.pin   = pin;
    r.want  = want;
    dir_rows.push_back(r);
  endfunction

  initial begin : stimulus
    las_cfg_t cfg_a;
    int       k;
    cfg_now = make_settings(1'b0, 0, 0, TOL_RESET, 0, STEP_LIM_RESET, TRAVEL_RESET);
    cfg_a   = make_settings(1'b1, 0, 2048, 57, 32767, 0, 0);

    add_row(0, OP_TICK,   12'd0,    16'd0,      1, {3'b000, ST_UNCAL, OC_NONE, 1'b0});
    add_row(0, OP_LOCK,   12'd4095, 16'hFFFF,   1, {3'b000, ST_UNCAL, OC_NOT_CAL, 1'b0});
    add_row(0, OP_UNLOCK, 12'd2048, 16'd0,      1, {3'b000, ST_UNCAL, OC_NOT_CAL, 1'b0});
    add_row(0, OP_SPARE,  12'd100,  16'h8000,   1, {3'b000, ST_UNCAL, OC_NONE, 1'b0});
    add_row(1, OP_TICK,   12'd0,    16'd0,      1, {3'b000, ST_LOCKED, OC_NONE, 1'b1});
    add_row(0, OP_LOCK,   12'd56,   16'd1,      1, {3'b000, ST_LOCKED, OC_OK, 1'b0});
    add_row(0, OP_LOCK,   12'd57,   16'd0,      1, {3'b001, ST_MOVING, OC_NONE, 1'b0});
    add_row(0, OP_TICK,   12'd4000, 16'd0,      1, {3'b101, ST_MOVING, OC_NONE, 1'b0});
    add_row(0, OP_LOCK,   12'd3000, 16'd0,      1, {3'b111, ST_UNLOCKED, OC_RETURNED, 1'b0});
    add_row(0, OP_UNLOCK, 12'd2048, 16'd0,      1, {3'b011, ST_MOVING, OC_NONE, 1'b1});
    add_row(0, OP_TICK,   12'd0,    16'hFFFF,   1, {3'b111, ST_MOVING, OC_NONE, 1'b0});
    add_row(0, OP_UNLOCK, 12'd4095, 16'd0,      1, {3'b111, ST_UNLOCKED, OC_OK, 1'b0});
    add_row(0, OP_SPARE,  12'd4095, 16'hFFFF,   0, '0);
    add_row(0, OP_TICK,   12'd2105, 16'h7FFF,   0, '0);
    add_row(0, OP_LOCK,   12'd2048, 16'd0,      0, '0);
    add_row(0, OP_TICK,   12'd4095, 16'h8000,   1, {3'b101, ST_LOCKED, OC_OK, 1'b0});
    add_row(0, OP_UNLOCK, 12'd1000, 16'hFFFE,   0, '0);
    add_row(0, OP_TICK,   12'd1000, 16'd0,      0, '0);
    add_row(0, OP_LOCK,   12'd1001, 16'hFFFF,   0, '0);
    add_row(0, OP_TICK,   12'd3000, 16'h5555,   0, '0);
    add_row(0, OP_LOCK,   12'd0,    16'hAAAA,   1, {3'b000, ST_LOCKED, OC_OK, 1'b1});

    repeat (5) @(negedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[i]) begin
      if (dir_rows[i].recfg) begin
        settle();
        write_settings(cfg_a);
      end
      pin_en  = dir_rows[i].pin;
      pin_val = dir_rows[i].want;
      send(dir_rows[i].it);
    end
    pin_en = 1'b0;

    run_phase(make_settings(1'b1, $urandom_range(0, 4095), $urandom_range(0, 4095),
                            $urandom_range(40, 120), 0, 120, $urandom_range(200, 1500)), 50, 40);
    run_phase(make_settings(1'b1, $urandom_range(0, 4095), $urandom_range(0, 4095),
                            $urandom_range(20, 100), 32767, 260, $urandom_range(300, 2000)),
              60, 40);
    run_phase(make_settings(1'b1, $urandom_range(0, 4095), $urandom_range(0, 4095),
                            0, $urandom_range(0, 32767), 60, 65535), 40, 40);
    run_phase(make_settings(1'b1, 4095, 0, 2048, $urandom_range(0, 32767), 65535, 0), 40, 40);
    run_phase(make_settings(1'b0, $urandom_range(0, 4095), $urandom_range(0, 4095),
                            57, 100, 50, 500), 30, 40);
    // long unlock moves: end on the reached travel target or on the doubled step cap
    run_phase(make_settings(1'b1, $urandom_range(0, 4095), $urandom_range(0, 4095),
                            30, 32767, 90, 65535), 200, 100);
    for (k = 0; k < 4; k++) run_phase(random_settings(), 30, 40);

    in_valid <= 1'b0;
    while (actuation_q.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
    if (bad_actuations == 0 && actuation_q.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
